// ===== rtl/rgbclp_pkg.sv =====
// Shared types and constants of the color line parser.
package rgbclp_pkg;

    // Byte classes handed from the front to the back.
    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_BLANK,
        CLS_DIGIT,
        CLS_COMMA,
        CLS_NEWLINE,
        CLS_CEIL,
        CLS_FLOOR
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        line_end;
    } token_t;

    typedef enum logic [2:0] {
        ST_NOT_COLOR = 3'd0,
        ST_ACCEPTED  = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FORMAT    = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    // Result word, first field in the highest bits.
    typedef struct packed {
        logic [1:0] accepted_total;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       is_floor;
        status_t    status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== rtl/rgbclp_front.sv =====
// Front end: accept input bytes and register their class.
module rgbclp_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_char,
    input  logic                  in_last,
    output logic                  tok_valid,
    input  logic                  tok_ready,
    output rgbclp_pkg::token_t    tok
);

    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [7:0] CHAR_F     = 8'h46;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    logic                 valid_reg;
    logic                 valid_next;
    rgbclp_pkg::token_t   tok_reg;
    rgbclp_pkg::token_t   tok_next;
    logic                 take;
    logic [7:0]           digit_off;

    assign in_ready  = !valid_reg || tok_ready;
    assign take      = in_valid && in_ready;
    assign digit_off = in_char - CHAR_ZERO;

    always_comb
    begin
        tok_next          = tok_reg;
        tok_next.digit    = digit_off[3:0];
        tok_next.line_end = in_last;
        priority if (in_char == CHAR_SPACE || in_char == CHAR_TAB)
            tok_next.cls = rgbclp_pkg::CLS_BLANK;
        else if (in_char >= CHAR_ZERO && in_char <= CHAR_NINE)
            tok_next.cls = rgbclp_pkg::CLS_DIGIT;
        else if (in_char == CHAR_COMMA)
            tok_next.cls = rgbclp_pkg::CLS_COMMA;
        else if (in_char == CHAR_LF)
            tok_next.cls = rgbclp_pkg::CLS_NEWLINE;
        else if (in_char == CHAR_C)
            tok_next.cls = rgbclp_pkg::CLS_CEIL;
        else if (in_char == CHAR_F)
            tok_next.cls = rgbclp_pkg::CLS_FLOOR;
        else
            tok_next.cls = rgbclp_pkg::CLS_OTHER;

        valid_next = valid_reg;
        if (tok_ready)
            valid_next = 1'b0;
        if (take)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            tok_reg <= tok_next;
    end

    assign tok_valid = valid_reg;
    assign tok       = tok_reg;

endmodule

// ===== rtl/rgbclp_queue.sv =====
// Short token queue between front and back.
module rgbclp_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  rgbclp_pkg::token_t    push_tok,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output rgbclp_pkg::token_t    pop_tok
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rgbclp_pkg::token_t  store_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_tok    = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_tok;
    end

endmodule

// ===== rtl/rgbclp_back.sv =====
// Back end: line parser state machine and registered result.
module rgbclp_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tok_valid,
    output logic                  tok_ready,
    input  rgbclp_pkg::token_t    tok,
    output logic                  res_valid,
    input  logic                  res_ready,
    output rgbclp_pkg::result_t   res
);

    typedef enum logic [2:0] {
        PH_START,
        PH_SECOND,
        PH_SKIPWS,
        PH_NEEDDIG,
        PH_INNUM,
        PH_HOLD
    } phase_t;

    localparam logic [8:0]  ACC_SAT   = 9'd256;
    localparam logic [8:0]  COLOR_MAX = 9'd255;
    localparam logic [11:0] SUM_SAT   = 12'd256;
    localparam logic [1:0]  IDX_RED   = 2'd0;
    localparam logic [1:0]  IDX_GREEN = 2'd1;
    localparam logic [1:0]  IDX_BLUE  = 2'd2;
    localparam logic [1:0]  CNT_MAX   = 2'd3;

    phase_t               phase_reg, phase_next;
    logic                 kind_reg, kind_next;
    logic [1:0]           idx_reg, idx_next;
    logic [8:0]           red_reg, red_next;
    logic [8:0]           green_reg, green_next;
    logic [8:0]           blue_reg, blue_next;
    rgbclp_pkg::status_t  pend_reg, pend_next;
    logic                 ceil_seen_reg, ceil_seen_next;
    logic                 floor_seen_reg, floor_seen_next;
    logic [1:0]           count_reg, count_next;
    logic                 res_valid_reg, res_valid_next;
    rgbclp_pkg::result_t  res_reg, res_next;

    logic                 pop;
    logic                 is_blank, is_digit;
    logic                 add_en;
    logic [8:0]           acc_sel;
    logic [11:0]          acc_sum;
    logic [8:0]           acc_new;
    rgbclp_pkg::status_t  line_status;

    assign tok_ready = !tok.line_end || !res_valid_reg || res_ready;
    assign pop       = tok_valid && tok_ready;
    assign is_blank  = (tok.cls == rgbclp_pkg::CLS_BLANK);
    assign is_digit  = (tok.cls == rgbclp_pkg::CLS_DIGIT);

    // Times-ten accumulate on the component being read, saturating at 256.
    always_comb
    begin
        unique case (idx_reg)
            IDX_RED:   acc_sel = red_reg;
            IDX_GREEN: acc_sel = green_reg;
            default:   acc_sel = blue_reg;
        endcase
        acc_sum = {acc_sel, 3'b000} + {2'b00, acc_sel, 1'b0} + {8'd0, tok.digit};
        acc_new = (acc_sum > SUM_SAT) ? ACC_SAT : acc_sum[8:0];
    end

    always_comb
    begin
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        idx_next        = idx_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        pend_next       = pend_reg;
        ceil_seen_next  = ceil_seen_reg;
        floor_seen_next = floor_seen_reg;
        count_next      = count_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        add_en          = 1'b0;
        line_status     = rgbclp_pkg::ST_NOT_COLOR;

        if (pop)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (tok.cls == rgbclp_pkg::CLS_CEIL ||
                        tok.cls == rgbclp_pkg::CLS_FLOOR)
                    begin
                        kind_next  = (tok.cls == rgbclp_pkg::CLS_FLOOR);
                        phase_next = PH_SECOND;
                    end
                    else
                    begin
                        pend_next  = rgbclp_pkg::ST_NOT_COLOR;
                        phase_next = PH_HOLD;
                    end
                end
                PH_SECOND:
                begin
                    priority if (!is_blank)
                    begin
                        pend_next  = rgbclp_pkg::ST_NOT_COLOR;
                        phase_next = PH_HOLD;
                    end
                    else if (kind_reg ? floor_seen_reg : ceil_seen_reg)
                    begin
                        pend_next  = rgbclp_pkg::ST_DUPLICATE;
                        phase_next = PH_HOLD;
                    end
                    else
                        phase_next = PH_SKIPWS;
                end
                PH_SKIPWS, PH_NEEDDIG:
                begin
                    priority if (phase_reg == PH_SKIPWS && is_blank)
                        phase_next = PH_SKIPWS;
                    else if (is_digit)
                    begin
                        add_en     = 1'b1;
                        phase_next = PH_INNUM;
                    end
                    else
                    begin
                        pend_next  = rgbclp_pkg::ST_FORMAT;
                        phase_next = PH_HOLD;
                    end
                end
                PH_INNUM:
                begin
                    priority if (is_digit)
                        add_en = 1'b1;
                    else if (tok.cls == rgbclp_pkg::CLS_COMMA && idx_reg != IDX_BLUE)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        phase_next = PH_NEEDDIG;
                    end
                    else if (tok.cls == rgbclp_pkg::CLS_NEWLINE && idx_reg == IDX_BLUE)
                    begin
                        if (red_reg > COLOR_MAX || green_reg > COLOR_MAX ||
                            blue_reg > COLOR_MAX)
                            pend_next = rgbclp_pkg::ST_RANGE;
                        else
                            pend_next = rgbclp_pkg::ST_ACCEPTED;
                        phase_next = PH_HOLD;
                    end
                    else
                    begin
                        pend_next  = rgbclp_pkg::ST_FORMAT;
                        phase_next = PH_HOLD;
                    end
                end
                default:
                    phase_next = PH_HOLD;
            endcase

            if (add_en)
            begin
                unique case (idx_reg)
                    IDX_RED:   red_next   = acc_new;
                    IDX_GREEN: green_next = acc_new;
                    default:   blue_next  = acc_new;
                endcase
            end

            if (tok.line_end)
            begin
                priority if (phase_next == PH_HOLD)
                    line_status = pend_next;
                else if (phase_next == PH_START || phase_next == PH_SECOND)
                    line_status = rgbclp_pkg::ST_NOT_COLOR;
                else
                    line_status = rgbclp_pkg::ST_FORMAT;

                res_next.status   = line_status;
                res_next.is_floor = (line_status != rgbclp_pkg::ST_NOT_COLOR) && kind_next;
                res_next.red      = 8'd0;
                res_next.green    = 8'd0;
                res_next.blue     = 8'd0;
                if (line_status == rgbclp_pkg::ST_ACCEPTED)
                begin
                    res_next.red   = red_next[7:0];
                    res_next.green = green_next[7:0];
                    res_next.blue  = blue_next[7:0];
                    if (kind_next)
                        floor_seen_next = 1'b1;
                    else
                        ceil_seen_next = 1'b1;
                    if (count_reg != CNT_MAX)
                        count_next = count_reg + 1'b1;
                end
                res_next.accepted_total = count_next;
                res_valid_next          = 1'b1;

                // Drop per-line state for the next line.
                phase_next = PH_START;
                kind_next  = 1'b0;
                idx_next   = IDX_RED;
                red_next   = '0;
                green_next = '0;
                blue_next  = '0;
                pend_next  = rgbclp_pkg::ST_NOT_COLOR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            kind_reg       <= 1'b0;
            idx_reg        <= IDX_RED;
            red_reg        <= '0;
            green_reg      <= '0;
            blue_reg       <= '0;
            pend_reg       <= rgbclp_pkg::ST_NOT_COLOR;
            ceil_seen_reg  <= 1'b0;
            floor_seen_reg <= 1'b0;
            count_reg      <= '0;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            idx_reg        <= idx_next;
            red_reg        <= red_next;
            green_reg      <= green_next;
            blue_reg       <= blue_next;
            pend_reg       <= pend_next;
            ceil_seen_reg  <= ceil_seen_next;
            floor_seen_reg <= floor_seen_next;
            count_reg      <= count_next;
            res_valid_reg  <= res_valid_next;
            res_reg        <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/rgb_color_line_parser_top.sv =====
// Top level of the color line parser: front, token queue and back.
//
//   port group      dir   word contents (lowest bit up)
//   s_axis_*        in    tdata[7:0] char_code, tlast line_end
//   m_axis_*        out   tdata status[2:0], is_floor[3], red[11:4],
//                         green[19:12], blue[27:20], accepted_total[29:28]
//
// One byte per cycle sustained while no line end is held up by a stalled m_axis;
// the back's parser state machine takes one queued byte each cycle. A line's
// result word passes the front register, the queue and the result register,
// and can be taken once the result register has been loaded.
// rst_n clears all line state, the seen flags and the accepted count.
// A stalled m_axis holds the result; the back keeps consuming bytes that do
// not end a line, and the queue and the front register absorb QUEUE_DEPTH
// words past the blocked line end before s_axis stalls.
module rgb_color_line_parser_top
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code[7:0]
    input  logic        s_axis_tlast,   // line_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], is_floor[3], red[11:4], green[19:12], blue[27:20],
    // accepted_total[29:28], zero fill[31:30]
    output logic [rgbclp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int PAD_W = rgbclp_pkg::OUT_DATA_W - rgbclp_pkg::RESULT_W;

    logic                  front_valid;
    logic                  front_ready;
    rgbclp_pkg::token_t    front_tok;
    logic                  back_valid;
    logic                  back_ready;
    rgbclp_pkg::token_t    back_tok;
    rgbclp_pkg::result_t   result;

    // Classify each byte as it is accepted.
    rgbclp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_char   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .tok_valid (front_valid),
        .tok_ready (front_ready),
        .tok       (front_tok)
    );

    // Decouple the front from result back-pressure.
    rgbclp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_tok   (front_tok),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_tok    (back_tok)
    );

    // Run the line parser and hold the verdict until taken.
    rgbclp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (back_valid),
        .tok_ready (back_ready),
        .tok       (back_tok),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (result)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, result};

endmodule

// ===== rtl/rgbclp_checker.sv =====
// Port-level checker for the color line parser, bound to the top level.
module rgbclp_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata
);

    // Hold a stalled result word.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] == rgbclp_pkg::ST_NOT_COLOR ||
                          m_axis_tdata[2:0] == rgbclp_pkg::ST_ACCEPTED ||
                          m_axis_tdata[2:0] == rgbclp_pkg::ST_DUPLICATE ||
                          m_axis_tdata[2:0] == rgbclp_pkg::ST_FORMAT ||
                          m_axis_tdata[2:0] == rgbclp_pkg::ST_RANGE)
        else $error("status code out of range");

    a_color_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != rgbclp_pkg::ST_ACCEPTED
            |-> m_axis_tdata[27:4] == 24'd0)
        else $error("color reported on a line that was not accepted");

    a_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] == rgbclp_pkg::ST_NOT_COLOR
            |-> !m_axis_tdata[3])
        else $error("floor flag set on a line that is not a color line");

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] == rgbclp_pkg::ST_ACCEPTED
            |-> m_axis_tdata[29:28] != 2'd0 && m_axis_tdata[31:30] == 2'd0)
        else $error("accepted line without a count");

endmodule

bind rgb_color_line_parser_top rgbclp_checker u_rgbclp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
